// ----- hdl/tds_pkg.sv -----
// ----------------------------------------------------------------------------
// tds_pkg: shared types and constants for the tangent-in-degrees block
// Fixed-point formats, queue item layout and status structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tds_pkg;

    // default parameter values
    localparam int SERIES_TERMS_DEF = 12;
    localparam int FRAC_BITS_DEF    = 16;

    // fixed widths
    localparam int ANGLE_W = 32;
    localparam int WORK_W  = 30;   // q30 radians, always below one
    localparam int TERM_W  = 31;   // q30 term, cosine starts at exactly one
    localparam int SUM_W   = 33;   // signed series sum
    localparam int QUO_W   = 33;   // quotient bits kept before saturation
    localparam int DEN_W   = 31;
    localparam int DIV_W   = 12;   // widest series divisor at the default term count is 22 * 23

    // pi in q60, radians per degree scaled by 2^38
    localparam logic [63:0] PI_Q60    = 64'h3243F6A8885A308D;
    localparam logic [32:0] RAD_K     = 33'((PI_Q60 >> 22) / 64'd180);
    localparam logic [31:0] RECIP_180 = 32'((64'd1 << 32) / 64'd180);
    localparam logic [TERM_W-1:0] WORK_ONE = TERM_W'(64'd1 << 30);

    // front to back queue
    localparam int QDEPTH = 8;
    localparam int QPTR_W = 3;
    localparam int QCNT_W = 4;

    typedef struct packed {
        logic neg;
        logic swap;
        logic inf;
    } t_flags;

    typedef struct packed {
        logic [WORK_W-1:0] theta;
        t_flags            flags;
    } t_q_item;

    typedef struct packed {
        logic              push;
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } t_q_status;

    typedef struct packed {
        logic   vld;
        t_flags flags;
    } t_line;

endpackage
`default_nettype wire

// ----- hdl/tan_degrees_series.sv -----
// ----------------------------------------------------------------------------
// tan_degrees_series: tangent of an angle in degrees, q16.16 fixed point
// Front reduces and converts the angle, a queue decouples, back evaluates.
// ----------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  angle     in         i_valid / o_stall   i_angle_deg
//  tangent   out        o_valid / i_stall   o_tan_value, o_is_infinite, o_saturated
//
//  one item per cycle sustained while neither i_stall nor o_stall holds it; an item passes
//  the front stages, the queue, the theta-squared register, the series stages, the
//  33-step divider pipeline and the result register
//  synchronous active-low reset clears all valid bits and the queue
//  a held result freezes the back pipeline; the front keeps taking items until
//  its in-flight items plus the queue fill would make the 8-entry queue full
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tan_degrees_series #(
    parameter int SERIES_TERMS = tds_pkg::SERIES_TERMS_DEF,
    parameter int FRAC_BITS    = tds_pkg::FRAC_BITS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire logic [31:0]    i_angle_deg,
    output logic                o_valid,
    input  wire logic           i_stall,
    output logic [31:0]         o_tan_value,
    output logic                o_is_infinite,
    output logic                o_saturated
);

    logic                   f_push;
    tds_pkg::t_q_item       f_item;
    tds_pkg::t_q_item       q_item;
    tds_pkg::t_q_status     q_stat;
    logic                   b_pop;

    tds_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_angle_deg (i_angle_deg),
        .i_q_count   (q_stat.count),
        .o_push      (f_push),
        .o_item      (f_item)
    );

    tds_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (f_push),
        .i_item   (f_item),
        .i_pop    (b_pop),
        .o_item   (q_item),
        .o_status (q_stat)
    );

    tds_back #(.SERIES_TERMS(SERIES_TERMS), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (q_item),
        .i_empty       (q_stat.empty),
        .o_pop         (b_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_tan_value   (o_tan_value),
        .o_is_infinite (o_is_infinite),
        .o_saturated   (o_saturated)
    );

    // infinite results carry zero and no clamp
    a_inf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_infinite |-> (o_tan_value == 32'h0) && !o_saturated)
        else $error("infinite result with nonzero value or clamp");

    // a clamp lands on a format limit
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturated |->
            (o_tan_value == 32'h7FFFFFFF) || (o_tan_value == 32'h80000000))
        else $error("clamped result off the format limits");

    // front credit keeps the queue from overflowing
    a_q_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.push |-> !q_stat.full)
        else $error("queue push while full");

endmodule
`default_nettype wire

// ----- hdl/tds_front.sv -----
// ----------------------------------------------------------------------------
// tds_front: angle reduction and conversion to radians
// Folds the angle into [0, 45] degrees and scales it to q30 radians.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tds_front #(
    parameter int FRAC_BITS = tds_pkg::FRAC_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic [tds_pkg::ANGLE_W-1:0]    i_angle_deg,
    input  wire logic [tds_pkg::QCNT_W-1:0]     i_q_count,
    output logic                                o_push,
    output tds_pkg::t_q_item                    o_item
);

    localparam int R_W   = FRAC_BITS + 8;
    localparam int PHI_W = FRAC_BITS + 6;
    localparam logic [R_W-1:0] HALF_TURN = R_W'(64'd180 << FRAC_BITS);
    localparam logic [R_W-1:0] RIGHT     = R_W'(64'd90 << FRAC_BITS);
    localparam logic [R_W-1:0] EIGHTH    = R_W'(64'd45 << FRAC_BITS);

    logic                   accept;
    logic [3:0]             inflight;
    logic [31:0]            mag;

    logic                   r_v1, r_v2, r_v3, r_v4;
    logic                   r_neg1;
    logic [31:0]            r_x1;
    logic [FRAC_BITS-1:0]   r_frac1;
    logic [31:0]            r_qest1;

    logic [31:0]            rem_raw, rem_fix;
    logic [R_W-1:0]         red, dd;
    tds_pkg::t_flags        flags2;
    logic [PHI_W-1:0]       phi2;

    tds_pkg::t_flags        r_flags2, r_flags3, r_flags4;
    logic [PHI_W-1:0]       r_phi2;
    logic [PHI_W+15:0]      r_plo3;
    logic [PHI_W+16:0]      r_phi3;
    logic [PHI_W+32:0]      rad_sum;
    logic [tds_pkg::WORK_W-1:0] r_theta4;

    // credit check against queue room
    always_comb begin
        inflight = 4'(r_v1) + 4'(r_v2) + 4'(r_v3) + 4'(r_v4) + 4'(i_q_count);
        o_stall  = (inflight >= 4'(tds_pkg::QDEPTH));
    end
    assign accept = i_valid && !o_stall;

    // magnitude and quotient estimate by 180
    assign mag = i_angle_deg[31] ? 32'(-i_angle_deg) : i_angle_deg;

    always_ff @(posedge i_clk) begin
        r_neg1  <= i_angle_deg[31];
        r_x1    <= mag >> FRAC_BITS;
        r_frac1 <= mag[FRAC_BITS-1:0];
        r_qest1 <= 32'((64'(mag >> FRAC_BITS) * 64'(tds_pkg::RECIP_180)) >> 32);
    end

    // remainder modulo 180 degrees, fold to the octant
    always_comb begin
        rem_raw = r_x1 - 32'(r_qest1 * 32'd180);
        rem_fix = (rem_raw >= 32'd180) ? rem_raw - 32'd180 : rem_raw;
        red     = {rem_fix[7:0], r_frac1};
        flags2.inf = (red == RIGHT);
        if (red > RIGHT) begin
            dd         = HALF_TURN - red;
            flags2.neg = !r_neg1;
        end else begin
            dd         = red;
            flags2.neg = r_neg1;
        end
        flags2.swap = (dd > EIGHTH);
        phi2 = flags2.swap ? PHI_W'(RIGHT - dd) : PHI_W'(dd);
    end

    always_ff @(posedge i_clk) begin
        r_flags2 <= flags2;
        r_phi2   <= phi2;
    end

    // degrees to radians, split into two partial products
    always_ff @(posedge i_clk) begin
        r_flags3 <= r_flags2;
        r_plo3   <= (PHI_W+16)'(r_phi2) * (PHI_W+16)'(tds_pkg::RAD_K[15:0]);
        r_phi3   <= (PHI_W+17)'(r_phi2) * (PHI_W+17)'(tds_pkg::RAD_K[32:16]);
    end

    assign rad_sum = {r_phi3, 16'b0} + (PHI_W+33)'(r_plo3);

    always_ff @(posedge i_clk) begin
        r_flags4 <= r_flags3;
        r_theta4 <= tds_pkg::WORK_W'(rad_sum >> (FRAC_BITS + 8));
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    assign o_push       = r_v4;
    assign o_item.theta = r_theta4;
    assign o_item.flags = r_flags4;

endmodule
`default_nettype wire

// ----- hdl/tds_queue.sv -----
// ----------------------------------------------------------------------------
// tds_queue: short fifo between front and back
// Holds reduced angles so each side can stall on its own.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tds_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  tds_pkg::t_q_item        i_item,
    input  wire logic               i_pop,
    output tds_pkg::t_q_item        o_item,
    output tds_pkg::t_q_status      o_status
);

    tds_pkg::t_q_item               r_mem [tds_pkg::QDEPTH];
    logic [tds_pkg::QPTR_W-1:0]     r_wr, r_rd;
    logic [tds_pkg::QCNT_W-1:0]     r_count;
    logic                           do_push, do_pop;

    assign do_push = i_push && (r_count != tds_pkg::QCNT_W'(tds_pkg::QDEPTH));
    assign do_pop  = i_pop && (r_count != '0);

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + tds_pkg::QCNT_W'(do_push) - tds_pkg::QCNT_W'(do_pop);
        end
    end

    assign o_item          = r_mem[r_rd];
    assign o_status.push   = i_push;
    assign o_status.full   = (r_count == tds_pkg::QCNT_W'(tds_pkg::QDEPTH));
    assign o_status.empty  = (r_count == '0);
    assign o_status.count  = r_count;

endmodule
`default_nettype wire

// ----- hdl/tds_series.sv -----
// ----------------------------------------------------------------------------
// tds_series: pipelined taylor series for sine or cosine
// Three stages per term: square product, reciprocal divide, correct and add.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tds_series #(
    parameter int SERIES_TERMS = tds_pkg::SERIES_TERMS_DEF,
    parameter bit SINE         = 1'b1
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_en,
    input  wire logic [tds_pkg::WORK_W-1:0]             i_theta,
    input  wire logic [tds_pkg::WORK_W-1:0]             i_t2,
    output logic signed [tds_pkg::SUM_W-1:0]            o_sum
);

    localparam int TW = tds_pkg::TERM_W;
    localparam int WW = tds_pkg::WORK_W;
    localparam int SW = tds_pkg::SUM_W;

    logic [TW-1:0]          r_ap   [1:SERIES_TERMS-1];
    logic [WW-1:0]          r_at2  [1:SERIES_TERMS-1];
    logic signed [SW-1:0]   r_asum [1:SERIES_TERMS-1];
    logic [TW-1:0]          r_bp   [1:SERIES_TERMS-1];
    logic [TW-1:0]          r_be   [1:SERIES_TERMS-1];
    logic [WW-1:0]          r_bt2  [1:SERIES_TERMS-1];
    logic signed [SW-1:0]   r_bsum [1:SERIES_TERMS-1];
    logic [TW-1:0]          r_cterm[1:SERIES_TERMS-1];
    logic [WW-1:0]          r_ct2  [1:SERIES_TERMS-1];
    logic signed [SW-1:0]   r_csum [1:SERIES_TERMS-1];

    genvar k;
    generate
        for (k = 1; k < SERIES_TERMS; k++) begin : g_term
            localparam int D = SINE ? (2 * k) * (2 * k + 1) : (2 * k - 1) * (2 * k);
            localparam logic [31:0] RCP = 32'((64'd1 << 32) / 64'(D));

            logic [TW-1:0]          prev_term;
            logic [WW-1:0]          prev_t2;
            logic signed [SW-1:0]   prev_sum;
            logic [TW-1:0]          rem;
            logic [TW-1:0]          quo;

            // previous term, first one straight from the angle for sine or exactly one for cosine
            if (k == 1) begin : g_first
                assign prev_term = SINE ? TW'(i_theta) : tds_pkg::WORK_ONE;
                assign prev_t2   = i_t2;
                assign prev_sum  = SINE ? SW'(i_theta) : SW'(tds_pkg::WORK_ONE);
            end else begin : g_next
                assign prev_term = r_cterm[k-1];
                assign prev_t2   = r_ct2[k-1];
                assign prev_sum  = r_csum[k-1];
            end

            // term times theta squared
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_ap[k]   <= TW'((61'(prev_term) * 61'(prev_t2)) >> 30);
                    r_at2[k]  <= prev_t2;
                    r_asum[k] <= prev_sum;
                end
            end

            // quotient estimate by reciprocal
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_bp[k]   <= r_ap[k];
                    r_be[k]   <= TW'((63'(r_ap[k]) * 63'(RCP)) >> 32);
                    r_bt2[k]  <= r_at2[k];
                    r_bsum[k] <= r_asum[k];
                end
            end

            // estimate may be one short
            always_comb begin
                rem = r_bp[k] - TW'(r_be[k] * TW'(D));
                quo = (rem >= TW'(D)) ? r_be[k] + 1'b1 : r_be[k];
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_cterm[k] <= quo;
                    r_ct2[k]   <= r_bt2[k];
                    if (k % 2 == 1) begin
                        r_csum[k] <= r_bsum[k] - $signed(SW'(quo));
                    end else begin
                        r_csum[k] <= r_bsum[k] + $signed(SW'(quo));
                    end
                end
            end
        end
    endgenerate

    assign o_sum = r_csum[SERIES_TERMS-1];

endmodule
`default_nettype wire

// ----- hdl/tds_divider.sv -----
// ----------------------------------------------------------------------------
// tds_divider: pipelined restoring divider
// One quotient bit per stage after an overflow precheck.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tds_divider #(
    parameter int FRAC_BITS = tds_pkg::FRAC_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_en,
    input  wire logic [tds_pkg::DEN_W-1:0]      i_num,
    input  wire logic [tds_pkg::DEN_W-1:0]      i_den,
    input  wire logic                           i_den_bad,
    output logic [tds_pkg::QUO_W-1:0]           o_quo,
    output logic                                o_ovf
);

    localparam int DW = tds_pkg::DEN_W;
    localparam int QW = tds_pkg::QUO_W;
    localparam int NW = DW + FRAC_BITS;

    logic [NW-1:0]  dividend;
    logic [NW-1:0]  hi_part;

    logic [DW-1:0]  r_rem [QW+1];
    logic [QW-1:0]  r_low [QW+1];
    logic [QW-1:0]  r_quo [QW+1];
    logic [DW-1:0]  r_den [QW+1];
    logic           r_ovf [QW+1];

    // quotient of 2^33 or more saturates anyway
    assign dividend = {i_num, FRAC_BITS'(0)};
    assign hi_part  = dividend >> QW;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= DW'(hi_part);
            r_low[0] <= dividend[QW-1:0];
            r_quo[0] <= '0;
            r_den[0] <= i_den;
            r_ovf[0] <= i_den_bad || (hi_part >= NW'(i_den));
        end
    end

    genvar s;
    generate
        for (s = 1; s <= QW; s++) begin : g_step
            logic [DW:0] trial;
            logic        fits;

            assign trial = {r_rem[s-1], r_low[s-1][QW-1]};
            assign fits  = (trial >= {1'b0, r_den[s-1]});

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s] <= fits ? DW'(trial - {1'b0, r_den[s-1]}) : DW'(trial);
                    r_low[s] <= {r_low[s-1][QW-2:0], 1'b0};
                    r_quo[s] <= {r_quo[s-1][QW-2:0], fits};
                    r_den[s] <= r_den[s-1];
                    r_ovf[s] <= r_ovf[s-1];
                end
            end
        end
    endgenerate

    assign o_quo = r_quo[QW];
    assign o_ovf = r_ovf[QW];

endmodule
`default_nettype wire

// ----- hdl/tds_back.sv -----
// ----------------------------------------------------------------------------
// tds_back: series evaluation, division and saturation
// Takes reduced angles from the queue and drives the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tds_back #(
    parameter int SERIES_TERMS = tds_pkg::SERIES_TERMS_DEF,
    parameter int FRAC_BITS    = tds_pkg::FRAC_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  tds_pkg::t_q_item                    i_item,
    input  wire logic                           i_empty,
    output logic                                o_pop,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic [31:0]                         o_tan_value,
    output logic                                o_is_infinite,
    output logic                                o_saturated
);

    localparam int SER_LAT = 3 * (SERIES_TERMS - 1);
    localparam int LINE_N  = 1 + SER_LAT + 1 + tds_pkg::QUO_W;
    localparam int WW      = tds_pkg::WORK_W;

    logic                           en;
    tds_pkg::t_line                 r_line [LINE_N];
    logic [WW-1:0]                  r_theta0, r_t20;
    logic signed [tds_pkg::SUM_W-1:0] sin_sum, cos_sum, num_s, den_s;
    logic [tds_pkg::DEN_W-1:0]      num_u, den_u;
    logic                           den_bad;
    logic [tds_pkg::QUO_W-1:0]      quo;
    logic                           ovf;
    tds_pkg::t_flags                fl;
    logic [31:0]                    val;
    logic                           sat;

    // whole pipeline moves unless the result register is held
    assign en    = !o_valid || !i_stall;
    assign o_pop = en && !i_empty;

    // theta squared
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_theta0 <= i_item.theta;
            r_t20    <= WW'((60'(i_item.theta) * 60'(i_item.theta)) >> 30);
        end
    end

    // valid and flag line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LINE_N; i++) begin
                r_line[i].vld <= 1'b0;
            end
        end else if (en) begin
            r_line[0].vld <= !i_empty;
            for (int i = 1; i < LINE_N; i++) begin
                r_line[i].vld <= r_line[i-1].vld;
            end
        end
        if (en) begin
            r_line[0].flags <= i_item.flags;
            for (int i = 1; i < LINE_N; i++) begin
                r_line[i].flags <= r_line[i-1].flags;
            end
        end
    end

    tds_series #(.SERIES_TERMS(SERIES_TERMS), .SINE(1'b1)) u_sin (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_theta (r_theta0),
        .i_t2    (r_t20),
        .o_sum   (sin_sum)
    );

    tds_series #(.SERIES_TERMS(SERIES_TERMS), .SINE(1'b0)) u_cos (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_theta (r_theta0),
        .i_t2    (r_t20),
        .o_sum   (cos_sum)
    );

    // pick numerator and denominator for the octant
    always_comb begin
        num_s   = r_line[SER_LAT].flags.swap ? cos_sum : sin_sum;
        den_s   = r_line[SER_LAT].flags.swap ? sin_sum : cos_sum;
        num_u   = num_s[tds_pkg::SUM_W-1] ? '0 : num_s[tds_pkg::DEN_W-1:0];
        den_bad = (den_s <= 0);
        den_u   = den_s[tds_pkg::DEN_W-1:0];
    end

    tds_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_num     (num_u),
        .i_den     (den_u),
        .i_den_bad (den_bad),
        .o_quo     (quo),
        .o_ovf     (ovf)
    );

    // sign and saturation
    always_comb begin
        fl  = r_line[LINE_N-1].flags;
        val = quo[31:0];
        sat = 1'b0;
        if (fl.inf) begin
            val = '0;
        end else if (fl.neg) begin
            if (ovf || (quo > 33'h080000000)) begin
                val = 32'h80000000;
                sat = 1'b1;
            end else begin
                val = 32'(-quo);
            end
        end else begin
            if (ovf || (quo > 33'h07FFFFFFF)) begin
                val = 32'h7FFFFFFF;
                sat = 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (en) begin
            o_valid <= r_line[LINE_N-1].vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_tan_value   <= val;
            o_is_infinite <= fl.inf;
            o_saturated   <= sat;
        end
    end

endmodule
`default_nettype wire
